// ===== design/bsd_pkg.sv =====
// Shared constants and types for the byte stream deframer.
`default_nettype none
package bsd_pkg;

	localparam int LEN_W     = 13;
	localparam int MAX_FRAME = 4096;
	localparam int Q_DEPTH   = 3;
	localparam int QC_W      = 2;

	localparam logic [7:0] MARK_BANG = 8'h21;
	localparam logic [7:0] MARK_AMP  = 8'h26;
	localparam logic [7:0] MARK_HASH = 8'h23;

	localparam logic [LEN_W-1:0] LIMIT_CAP   = LEN_W'(MAX_FRAME);
	localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(4096);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_BANG    = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_HELD    = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             has_byte;
		logic             frame_end;
		logic [LEN_W-1:0] frame_length;
		logic             overflow;
	} result_t;

endpackage
`default_nettype wire

// ===== design/byte_stream_deframer.sv =====
// Byte stream deframer top level: frame hunt, payload release and result queue.
//
// Input channel (in_valid, in_stall, in_byte) takes one raw link byte per request.
// The block hunts for the pair '!' '&', passes payload bytes until the pair '!' '#',
// and then emits one end item with the kept payload length and an overflow flag.
// A '!' inside a payload is held until the next byte; that byte may release two
// payload items at once.
// Output channel (out_valid, out_stall, data_byte, has_byte, frame_end,
// frame_length, overflow) carries one result per request.
// Configuration channel (cfg_valid, cfg_ready, cfg_data) writes max_payload; it is
// always ready; the user must write it only while the block is idle; not enforced.
// A byte goes through the input register and then the result queue. Throughput: one
// byte per cycle while each byte yields at most one result and the receiver does not
// stall; the three-entry result queue and one output per cycle bound the rest.
// A byte is held in the input register until the queue has room for two results.
// When the receiver stalls, the queue fills and in_stall rises; nothing is lost.
// Reset clears the phase, count, flag and queue, and sets max_payload to 4096.
`default_nettype none
module byte_stream_deframer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [7:0]                in_byte,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [7:0]                     data_byte,
	output logic                           has_byte,
	output logic                           frame_end,
	output logic [bsd_pkg::LEN_W-1:0]      frame_length,
	output logic                           overflow,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [bsd_pkg::LEN_W-1:0] cfg_data
);
	import bsd_pkg::*;

	logic [LEN_W-1:0] max_payload_q;
	logic [LEN_W-1:0] lim;

	logic       byte_v_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       in_acc;

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] kept_q, kept_d;
	logic             drop_q, drop_d;

	logic             want_a, want_b;
	logic [7:0]       byte_a, byte_b;
	logic             ok_a, ok_b;
	logic [LEN_W-1:0] kept_a;
	logic             end_item;
	result_t          res0, res1;
	logic [1:0]       n_res;

	result_t          e_q [Q_DEPTH];
	result_t          e_d [Q_DEPTH];
	logic [QC_W-1:0]  cnt_q, cnt_d;
	logic [QC_W-1:0]  base;
	logic [1:0]       n_eff;
	logic             pop;

	assign cfg_ready = 1'b1;
	assign lim       = (max_payload_q > LIMIT_CAP) ? LIMIT_CAP : max_payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	// input register
	assign adv      = byte_v_s1 && (cnt_q <= QC_W'(1));
	assign in_stall = byte_v_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_v_s1 <= 1'b0;
		end else if (in_acc) begin
			byte_v_s1 <= 1'b1;
		end else if (adv) begin
			byte_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_byte;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			kept_q  <= '0;
			drop_q  <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_d;
			kept_q  <= kept_d;
			drop_q  <= drop_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		want_a   = 1'b0;
		want_b   = 1'b0;
		byte_a   = byte_s1;
		byte_b   = byte_s1;
		end_item = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == MARK_BANG) begin
					phase_d = PH_BANG;
				end
			end
			PH_BANG: begin
				phase_d = (byte_s1 == MARK_AMP) ? PH_PAYLOAD : PH_HUNT;
			end
			PH_PAYLOAD: begin
				if (byte_s1 == MARK_BANG) begin
					phase_d = PH_HELD;
				end else begin
					want_a = 1'b1;
				end
			end
			PH_HELD: begin
				if (byte_s1 == MARK_HASH) begin
					end_item = 1'b1;
					phase_d  = PH_HUNT;
				end else if (byte_s1 == MARK_BANG) begin
					want_a = 1'b1;
					byte_a = MARK_BANG;
				end else begin
					want_a  = 1'b1;
					byte_a  = MARK_BANG;
					want_b  = 1'b1;
					phase_d = PH_PAYLOAD;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase

		ok_a   = want_a && (kept_q < lim);
		kept_a = kept_q + LEN_W'(ok_a);
		ok_b   = want_b && (kept_a < lim);

		kept_d = kept_a + LEN_W'(ok_b);
		drop_d = drop_q || (want_a && !ok_a) || (want_b && !ok_b);
		if (end_item || (phase_q == PH_BANG && byte_s1 == MARK_AMP)) begin
			kept_d = '0;
			drop_d = 1'b0;
		end

		res0  = '0;
		res1  = '0;
		n_res = 2'd0;
		if (end_item) begin
			res0.frame_end    = 1'b1;
			res0.frame_length = kept_q;
			res0.overflow     = drop_q;
			n_res             = 2'd1;
		end else if (ok_a) begin
			res0.data_byte = byte_a;
			res0.has_byte  = 1'b1;
			n_res          = 2'd1;
			if (ok_b) begin
				res1.data_byte = byte_b;
				res1.has_byte  = 1'b1;
				n_res          = 2'd2;
			end
		end else if (ok_b) begin
			res0.data_byte = byte_b;
			res0.has_byte  = 1'b1;
			n_res          = 2'd1;
		end
	end

	// result queue, head at entry 0
	assign pop   = out_valid && !out_stall;
	assign base  = cnt_q - QC_W'(pop);
	assign n_eff = adv ? n_res : 2'd0;
	assign cnt_d = base + QC_W'(n_eff);

	always_comb begin
		for (int i = 0; i < Q_DEPTH; i++) begin
			if (pop && i < Q_DEPTH - 1) begin
				e_d[i] = e_q[i+1];
			end else begin
				e_d[i] = e_q[i];
			end
			if (QC_W'(i) >= base) begin
				if (QC_W'(i) == base && n_eff != 2'd0) begin
					e_d[i] = res0;
				end else if (QC_W'(i) == base + QC_W'(1) && n_eff == 2'd2) begin
					e_d[i] = res1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < Q_DEPTH; i++) begin
			e_q[i] <= e_d[i];
		end
	end

	assign out_valid    = (cnt_q != '0);
	assign data_byte    = e_q[0].data_byte;
	assign has_byte     = e_q[0].has_byte;
	assign frame_end    = e_q[0].frame_end;
	assign frame_length = e_q[0].frame_length;
	assign overflow     = e_q[0].overflow;

endmodule
`default_nettype wire

// ===== design/byte_stream_deframer_chk.sv =====
// Port-level checker for the byte stream deframer, bound to the top level.
`default_nettype none
module bsd_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic [7:0]                data_byte,
	input wire logic                      has_byte,
	input wire logic                      frame_end,
	input wire logic [bsd_pkg::LEN_W-1:0] frame_length,
	input wire logic                      overflow
);
	import bsd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(frame_end))
		else $error("stalled result changed");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (has_byte != frame_end))
		else $error("result is neither payload nor end item");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_byte |-> frame_length == '0 && !overflow)
		else $error("payload item carries end fields");

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> data_byte == 8'h00 && frame_length <= LIMIT_CAP)
		else $error("end item malformed");

endmodule

bind byte_stream_deframer bsd_chk u_bsd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.data_byte    (data_byte),
	.has_byte     (has_byte),
	.frame_end    (frame_end),
	.frame_length (frame_length),
	.overflow     (overflow)
);
`default_nettype wire

// ===== tb/sv/tb_byte_stream_deframer.sv =====
// Testbench for byte_stream_deframer: random framed byte streams checked against a predictor.
`default_nettype none
module tb_byte_stream_deframer;
	import bsd_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       in_byte;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       data_byte;
	logic             has_byte;
	logic             frame_end;
	logic [LEN_W-1:0] frame_length;
	logic             overflow;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data;

	byte_stream_deframer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.out_valid(out_valid), .out_stall(out_stall), .data_byte(data_byte),
		.has_byte(has_byte), .frame_end(frame_end), .frame_length(frame_length),
		.overflow(overflow),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// link bytes waiting to be driven, and results the deframer owes
	logic [7:0]       link_bytes[$];
	result_t          owed_results[$];

	// predictor state
	phase_t           hunt_phase;
	logic [LEN_W-1:0] kept_count;
	logic             dropped;
	logic [LEN_W-1:0] max_payload;

	int               send_idle_pct;
	int               stall_pct;
	logic             byte_taken;
	int               errors;
	int               bytes_sent;
	int               payload_seen;
	int               frames_seen;
	int               overflows_seen;
	int               limit_writes;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic logic [LEN_W-1:0] kept_limit();
		return (max_payload > LIMIT_CAP) ? LIMIT_CAP : max_payload;
	endfunction

	task automatic keep_payload(input logic [7:0] b);
		result_t r;
		if (kept_count >= kept_limit()) begin
			dropped = 1'b1;
		end else begin
			kept_count = kept_count + 1'b1;
			r = '0;
			r.data_byte = b;
			r.has_byte = 1'b1;
			owed_results.push_back(r);
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		result_t r;
		case (hunt_phase)
			PH_HUNT: begin
				if (b == MARK_BANG)
					hunt_phase = PH_BANG;
			end
			PH_BANG: begin
				if (b == MARK_AMP) begin
					hunt_phase = PH_PAYLOAD;
					kept_count = '0;
					dropped = 1'b0;
				end else begin
					hunt_phase = PH_HUNT;
				end
			end
			PH_PAYLOAD: begin
				if (b == MARK_BANG)
					hunt_phase = PH_HELD;
				else
					keep_payload(b);
			end
			default: begin
				if (b == MARK_HASH) begin
					r = '0;
					r.frame_end = 1'b1;
					r.frame_length = kept_count;
					r.overflow = dropped;
					owed_results.push_back(r);
					hunt_phase = PH_HUNT;
					kept_count = '0;
					dropped = 1'b0;
				end else if (b == MARK_BANG) begin
					keep_payload(MARK_BANG);
				end else begin
					keep_payload(MARK_BANG);
					keep_payload(b);
					hunt_phase = PH_PAYLOAD;
				end
			end
		endcase
	endtask

	// monitor: check results, then predict from the byte taken at this edge
	always @(posedge clk) begin : watch_ports
		result_t want;
		byte_taken = in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_results.size() == 0) begin
				report("result with nothing owed");
			end else begin
				want = owed_results.pop_front();
				if (has_byte !== want.has_byte)
					report($sformatf("has_byte %b want %b", has_byte, want.has_byte));
				if (data_byte !== want.data_byte)
					report($sformatf("data_byte %h want %h", data_byte, want.data_byte));
				if (frame_end !== want.frame_end)
					report($sformatf("frame_end %b want %b", frame_end, want.frame_end));
				if (frame_length !== want.frame_length)
					report($sformatf("frame_length %0d want %0d", frame_length,
						want.frame_length));
				if (overflow !== want.overflow)
					report($sformatf("overflow %b want %b", overflow, want.overflow));
				if (want.frame_end) begin
					frames_seen++;
					if (want.overflow)
						overflows_seen++;
				end else begin
					payload_seen++;
				end
			end
		end
		if (arst_n && byte_taken) begin
			bytes_sent++;
			deframe_byte(in_byte);
		end
	end

	// driver: next request only once the current one was taken
	always @(negedge clk) begin : drive_ports
		logic       nxt_valid;
		logic [7:0] nxt_byte;
		nxt_valid = in_valid;
		nxt_byte = in_byte;
		if (!in_valid || byte_taken) begin
			nxt_valid = 1'b0;
			if (link_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt_valid = 1'b1;
				nxt_byte = link_bytes.pop_front();
			end
		end
		in_valid <= nxt_valid;
		in_byte <= nxt_byte;
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic [7:0] payload_pick(input logic [7:0] prev);
		int      roll;
		logic [7:0] b;
		roll = $urandom_range(11);
		if (roll < 2)
			b = MARK_BANG;
		else if (roll == 2)
			b = MARK_HASH;
		else if (roll == 3)
			b = MARK_AMP;
		else
			b = 8'($urandom_range(255));
		// keep a payload '!' from closing the frame early
		if (prev == MARK_BANG && b == MARK_HASH)
			b = 8'h00;
		return b;
	endfunction

	task automatic add_frame(input int len, input bit closed);
		logic [7:0] prev;
		prev = 8'h00;
		link_bytes.push_back(MARK_BANG);
		link_bytes.push_back(MARK_AMP);
		repeat (len) begin
			prev = payload_pick(prev);
			link_bytes.push_back(prev);
		end
		if (closed) begin
			link_bytes.push_back(MARK_BANG);
			link_bytes.push_back(MARK_HASH);
		end
	endtask

	task automatic add_noise(input int n);
		int roll;
		repeat (n) begin
			roll = $urandom_range(5);
			if (roll == 0)
				link_bytes.push_back(MARK_BANG);
			else if (roll == 1)
				link_bytes.push_back(MARK_AMP);
			else
				link_bytes.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic fill_random(input int budget);
		int base;
		int roll;
		base = link_bytes.size();
		while (link_bytes.size() - base < budget) begin
			roll = $urandom_range(9);
			if (roll < 7)
				add_frame(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12),
					1'b1);
			else if (roll == 7)
				add_frame($urandom_range(6), 1'b0);
			else
				add_noise($urandom_range(1, 6));
		end
	endtask

	task automatic wait_quiet();
		do
			@(posedge clk);
		while (link_bytes.size() > 0 || in_valid || owed_results.size() > 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LEN_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		max_payload = v;
		limit_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : run_stimulus
		logic [LEN_W-1:0] limits[10];
		int               p;
		limits = '{LIMIT_RESET, 13'd3, 13'd0, 13'd1, 13'd8191,
			13'd4096, 13'd4097, 13'd2, 13'd5, 13'd20};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		byte_taken = 1'b0;
		errors = 0;
		bytes_sent = 0;
		payload_seen = 0;
		frames_seen = 0;
		overflows_seen = 0;
		limit_writes = 0;
		hunt_phase = PH_HUNT;
		kept_count = '0;
		dropped = 1'b0;
		max_payload = LIMIT_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: hunt noise, bang-bang in hunt, extreme bytes, held-bang cases
		link_bytes = '{MARK_HASH, MARK_BANG, MARK_BANG, MARK_AMP,
			MARK_BANG, MARK_AMP, 8'h00, 8'hFF,
			MARK_BANG, MARK_BANG, 8'h41, MARK_AMP,
			MARK_BANG, MARK_HASH,
			MARK_BANG, MARK_AMP, MARK_BANG, MARK_HASH,
			MARK_BANG, 8'h26};
		wait_quiet();

		for (p = 0; p < 10; p++) begin
			if (p > 0)
				write_limit(limits[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 67; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 67; end
				default: begin send_idle_pct = 26; stall_pct = 26; end
			endcase
			fill_random(60);
			// sender holds off until every owed result is out
			wait_quiet();
			fill_random(60);
			wait_quiet();
		end

		if (owed_results.size() != 0)
			report($sformatf("%0d results never came", owed_results.size()));
		$display("sent %0d bytes over %0d limit writes and four idle/stall mixes",
			bytes_sent, limit_writes);
		$display("checked %0d payload bytes and %0d frame ends, %0d with overflow",
			payload_seen, frames_seen, overflows_seen);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
